### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plm assertion failed");

// Check that cons holds in the cycle after ante.
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plm assertion failed");

`endif

### src/plm_pkg.sv
// Types, constants and helper functions of the piecewise linear table mapper.
package plm_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REC_W       = 32;
  localparam int KEY_W       = 17;
  localparam int DIFF_W      = KEY_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int MAG_W       = PROD_W - 1;
  localparam int DMAG_W      = DIFF_W;
  localparam int QSUM_W      = PROD_W + 1;
  localparam int DIV_STEPS   = MAG_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_INVERSE = 2'd2,
    CMD_NONE    = 2'd3
  } command_e;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_ONE,
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_LO_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    CLS_BELOW,
    CLS_BEYOND,
    CLS_SEGMENT
  } class_e;

  typedef struct packed {
    logic    load;
    logic    wr;
    rd_sel_e rd_sel;
    logic    cap_first;
    logic    cap_second;
    logic    decide;
    logic    compare;
    logic    cap_seg0;
    logic    cap_seg1;
    logic    diff;
    logic    mul;
    logic    div_load;
    logic    div_step;
    logic    out_load;
  } plm_cmd_t;

  typedef struct packed {
    logic end_case;
    logic lo_lt_hi;
    logic div_done;
    logic out_free;
  } plm_sts_t;

  // Search key of a stored record {representation, value}.
  function automatic logic signed [KEY_W-1:0] rec_key(input logic fwd,
                                                      input logic [REC_W-1:0] rec);
    return fwd ? $signed({1'b0, rec[31:16]}) : $signed({rec[15], rec[15:0]});
  endfunction

  // Interpolated field of a stored record.
  function automatic logic signed [KEY_W-1:0] rec_out(input logic fwd,
                                                      input logic [REC_W-1:0] rec);
    return fwd ? $signed({rec[15], rec[15:0]}) : $signed({1'b0, rec[31:16]});
  endfunction

  // True when key b lies at or beyond breakpoint a in table direction.
  function automatic logic at_or_beyond(input logic falling,
                                        input logic signed [KEY_W-1:0] a,
                                        input logic signed [KEY_W-1:0] b);
    return falling ? (a >= b) : (a <= b);
  endfunction

endpackage

### src/plm_datapath.sv
// Table memory, search registers, multiplier, divider and result register.
module plm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plm_pkg::plm_cmd_t cmd_i,
  output plm_pkg::plm_sts_t sts_o,
  input  logic [1:0]        command_i,
  input  logic [6:0]        entry_index_i,
  input  logic [15:0]       representation_i,
  input  logic [15:0]       value_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [15:0]       mapped_value_o,
  output logic [15:0]       mapped_representation_o,
  output logic              exact_hit_o,
  output logic              in_span_o,
  output logic              clamped_o
);

  logic [7:0]                         entry_count_q;
  logic [plm_pkg::REC_W-1:0]          mem_q [plm_pkg::TABLE_DEPTH];
  logic [plm_pkg::REC_W-1:0]          rd_data_q;
  logic [plm_pkg::ADDR_W-1:0]         rd_addr;
  logic [plm_pkg::CNT_W-1:0]          n;
  logic [plm_pkg::ADDR_W-1:0]         last_addr, mid;
  logic [plm_pkg::ADDR_W:0]           mid_sum;

  logic                               fwd_q, falling_q, span_q, clamp_q, hit_q;
  logic signed [plm_pkg::KEY_W-1:0]   key_q;
  logic [plm_pkg::REC_W-1:0]          first_q, second_q, last_q, seg0_q, seg1_q;
  plm_pkg::class_e                    class_q, class_d;
  logic [plm_pkg::ADDR_W-1:0]         lo_q, hi_q;
  logic signed [plm_pkg::DIFF_W-1:0]  den_q, kd_q, od_q;
  logic signed [plm_pkg::PROD_W-1:0]  prod_q;
  logic                               neg_q;
  logic [plm_pkg::MAG_W-1:0]          nmag_q, quo_q;
  logic [plm_pkg::DMAG_W-1:0]         dmag_q, rem_q;
  logic [plm_pkg::DCNT_W-1:0]         div_cnt_q;
  logic                               out_valid_q;

  logic                               falling_d, span_d, clamp_d, hit_d;
  logic signed [plm_pkg::KEY_W-1:0]   first_k, last_k;
  logic [plm_pkg::DMAG_W:0]           rem_shift;
  logic signed [plm_pkg::PROD_W-1:0]  q_signed;
  logic signed [plm_pkg::QSUM_W-1:0]  res;
  logic signed [plm_pkg::KEY_W-1:0]   seg_start;
  logic                               interp_ok;
  logic [15:0]                        sat_val, sat_rep;

  // Active entry count, limited to 1..TABLE_DEPTH.
  always_comb begin
    if (entry_count_q == 8'd0) begin
      n = plm_pkg::CNT_W'(1);
    end else if (int'(entry_count_q) > plm_pkg::TABLE_DEPTH) begin
      n = plm_pkg::CNT_W'(plm_pkg::TABLE_DEPTH);
    end else begin
      n = plm_pkg::CNT_W'(entry_count_q);
    end
  end

  assign last_addr = plm_pkg::ADDR_W'(n - plm_pkg::CNT_W'(1));
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + (plm_pkg::ADDR_W + 1)'(1);
  assign mid       = mid_sum[plm_pkg::ADDR_W:1];

  always_comb begin
    unique case (cmd_i.rd_sel)
      plm_pkg::RD_ZERO:    rd_addr = '0;
      plm_pkg::RD_ONE:     rd_addr = plm_pkg::ADDR_W'(1);
      plm_pkg::RD_LAST:    rd_addr = last_addr;
      plm_pkg::RD_MID:     rd_addr = mid;
      plm_pkg::RD_LO:      rd_addr = lo_q;
      plm_pkg::RD_LO_NEXT: rd_addr = lo_q + plm_pkg::ADDR_W'(1);
      default:             rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (int'(entry_index_i) < plm_pkg::TABLE_DEPTH)) begin
      mem_q[plm_pkg::ADDR_W'(entry_index_i)] <= {representation_i, value_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 8'd1;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // Classify the key against the end entries; last entry arrives on rd_data_q.
  always_comb begin
    first_k   = plm_pkg::rec_key(fwd_q, first_q);
    last_k    = plm_pkg::rec_key(fwd_q, rd_data_q);
    falling_d = !fwd_q && (n >= plm_pkg::CNT_W'(2)) &&
                ($signed(second_q[15:0]) < $signed(first_q[15:0]));
    clamp_d   = 1'b0;
    hit_d     = 1'b0;
    if (!plm_pkg::at_or_beyond(falling_d, first_k, key_q)) begin
      class_d = plm_pkg::CLS_BELOW;
      clamp_d = 1'b1;
    end else if (plm_pkg::at_or_beyond(falling_d, last_k, key_q)) begin
      class_d = plm_pkg::CLS_BEYOND;
      clamp_d = (key_q != last_k);
      hit_d   = fwd_q && (key_q == last_k);
    end else begin
      class_d = plm_pkg::CLS_SEGMENT;
    end
    if (n == plm_pkg::CNT_W'(1)) begin
      span_d = (key_q == first_k);
    end else begin
      span_d = plm_pkg::at_or_beyond(falling_d, first_k, key_q) &&
               plm_pkg::at_or_beyond(falling_d, key_q, last_k);
    end
  end

  assign rem_shift = {rem_q, nmag_q[plm_pkg::MAG_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fwd_q <= (command_i == plm_pkg::CMD_FORWARD);
      key_q <= (command_i == plm_pkg::CMD_FORWARD) ? $signed({1'b0, representation_i})
                                                    : $signed({value_i[15], value_i});
    end
    if (cmd_i.cap_first)  first_q  <= rd_data_q;
    if (cmd_i.cap_second) second_q <= rd_data_q;
    if (cmd_i.decide) begin
      last_q    <= rd_data_q;
      falling_q <= falling_d;
      class_q   <= class_d;
      span_q    <= span_d;
      clamp_q   <= clamp_d;
      hit_q     <= hit_d;
      lo_q      <= '0;
      hi_q      <= plm_pkg::ADDR_W'(n - plm_pkg::CNT_W'(2));
    end
    if (cmd_i.compare) begin
      if (plm_pkg::at_or_beyond(falling_q, plm_pkg::rec_key(fwd_q, rd_data_q), key_q)) begin
        lo_q <= mid;
      end else begin
        hi_q <= mid - plm_pkg::ADDR_W'(1);
      end
    end
    if (cmd_i.cap_seg0) seg0_q <= rd_data_q;
    if (cmd_i.cap_seg1) seg1_q <= rd_data_q;
    if (cmd_i.diff) begin
      den_q <= plm_pkg::DIFF_W'(plm_pkg::rec_key(fwd_q, seg1_q)) -
               plm_pkg::DIFF_W'(plm_pkg::rec_key(fwd_q, seg0_q));
      kd_q  <= plm_pkg::DIFF_W'(key_q) - plm_pkg::DIFF_W'(plm_pkg::rec_key(fwd_q, seg0_q));
      od_q  <= plm_pkg::DIFF_W'(plm_pkg::rec_out(fwd_q, seg1_q)) -
               plm_pkg::DIFF_W'(plm_pkg::rec_out(fwd_q, seg0_q));
    end
    if (cmd_i.mul) begin
      prod_q <= kd_q * od_q;
    end
    if (cmd_i.div_load) begin
      neg_q     <= prod_q[plm_pkg::PROD_W-1] ^ den_q[plm_pkg::DIFF_W-1];
      nmag_q    <= plm_pkg::MAG_W'(prod_q[plm_pkg::PROD_W-1] ? -prod_q : prod_q);
      dmag_q    <= plm_pkg::DMAG_W'(den_q[plm_pkg::DIFF_W-1] ? -den_q : den_q);
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= plm_pkg::DCNT_W'(plm_pkg::DIV_STEPS);
    end else if (cmd_i.div_step) begin
      nmag_q    <= nmag_q << 1;
      div_cnt_q <= div_cnt_q - plm_pkg::DCNT_W'(1);
      if (rem_shift >= {1'b0, dmag_q}) begin
        rem_q <= plm_pkg::DMAG_W'(rem_shift - {1'b0, dmag_q});
        quo_q <= {quo_q[plm_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= plm_pkg::DMAG_W'(rem_shift);
        quo_q <= {quo_q[plm_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // Final result: end entry, segment start, or start plus signed quotient.
  always_comb begin
    seg_start = plm_pkg::rec_out(fwd_q, seg0_q);
    interp_ok = fwd_q ? (den_q > 0) : (den_q != 0);
    q_signed  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    unique case (class_q)
      plm_pkg::CLS_BELOW:  res = plm_pkg::QSUM_W'(plm_pkg::rec_out(fwd_q, first_q));
      plm_pkg::CLS_BEYOND: res = plm_pkg::QSUM_W'(plm_pkg::rec_out(fwd_q, last_q));
      default: begin
        if (interp_ok) begin
          res = plm_pkg::QSUM_W'(seg_start) + plm_pkg::QSUM_W'(q_signed);
        end else begin
          res = plm_pkg::QSUM_W'(seg_start);
        end
      end
    endcase
    if (res > 32767) begin
      sat_val = 16'h7FFF;
    end else if (res < -32768) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = res[15:0];
    end
    if (res > 65535) begin
      sat_rep = 16'hFFFF;
    end else if (res < 0) begin
      sat_rep = 16'h0000;
    end else begin
      sat_rep = res[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mapped_value_o          <= fwd_q ? sat_val : 16'h0000;
      mapped_representation_o <= fwd_q ? 16'h0000 : sat_rep;
      exact_hit_o             <= (class_q == plm_pkg::CLS_SEGMENT)
                                 ? (fwd_q && (plm_pkg::rec_key(fwd_q, seg0_q) == key_q))
                                 : hit_q;
      in_span_o               <= span_q;
      clamped_o               <= clamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.end_case  = (class_d != plm_pkg::CLS_SEGMENT);
  assign sts_o.lo_lt_hi  = (lo_q < hi_q);
  assign sts_o.div_done  = (div_cnt_q == plm_pkg::DCNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### src/plm_ctrl.sv
// Sequencer for table reads, binary search, multiply and divide.
module plm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_command_i,
  output logic              in_ready_o,
  input  plm_pkg::plm_sts_t sts_i,
  output plm_pkg::plm_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD0  = 13'b0000000000010,
    ST_RD1  = 13'b0000000000100,
    ST_RDL  = 13'b0000000001000,
    ST_DEC  = 13'b0000000010000,
    ST_SRCH = 13'b0000000100000,
    ST_CMP  = 13'b0000001000000,
    ST_SEG0 = 13'b0000010000000,
    ST_SEG1 = 13'b0000100000000,
    ST_DIFF = 13'b0001000000000,
    ST_MUL  = 13'b0010000000000,
    ST_DIV  = 13'b0100000000000,
    ST_RES  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   cmd_load_pending_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = plm_pkg::RD_ZERO;
    cmd_o.load     = accept;
    cmd_o.wr       = accept && (in_command_i == plm_pkg::CMD_WRITE);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && ((in_command_i == plm_pkg::CMD_FORWARD) ||
                       (in_command_i == plm_pkg::CMD_INVERSE))) begin
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd_o.rd_sel = plm_pkg::RD_ZERO;
        state_d      = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_sel    = plm_pkg::RD_ONE;
        cmd_o.cap_first = 1'b1;
        state_d         = ST_RDL;
      end
      ST_RDL: begin
        cmd_o.rd_sel     = plm_pkg::RD_LAST;
        cmd_o.cap_second = 1'b1;
        state_d          = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.end_case ? ST_RES : ST_SRCH;
      end
      ST_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rd_sel = plm_pkg::RD_MID;
          state_d      = ST_CMP;
        end else begin
          cmd_o.rd_sel = plm_pkg::RD_LO;
          state_d      = ST_SEG0;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_SRCH;
      end
      ST_SEG0: begin
        cmd_o.rd_sel   = plm_pkg::RD_LO_NEXT;
        cmd_o.cap_seg0 = 1'b1;
        state_d        = ST_SEG1;
      end
      ST_SEG1: begin
        cmd_o.cap_seg1 = 1'b1;
        state_d        = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
        // load the divider in the next cycle from the registered product
      end
      ST_DIV: begin
        if (cmd_load_pending_q) begin
          cmd_o.div_load = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_done) begin
            state_d = ST_RES;
          end
        end
      end
      ST_RES: begin
        // hold the result until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      cmd_load_pending_q <= 1'b0;
    end else begin
      state_q            <= state_d;
      cmd_load_pending_q <= (state_q == ST_MUL);
    end
  end

endmodule

### src/piecewise_linear_table_mapper_top.sv
// Piecewise linear lookup table with forward and inverse interpolation.
//
// Input stream s_axis carries one request per item: tuser selects write,
// forward lookup or inverse lookup; tdata carries the entry index, the
// representation and the Q8.8 value. A write stores one breakpoint pair in
// the table and gives no result. A lookup gives one result on m_axis: the
// interpolated value or representation in tdata, the hit, span and clamp
// flags in tuser. cfg_we_i/cfg_wdata_i set the number of entries in use.
// A lookup reads the first, second and last entries; a key outside the table
// goes straight to the result, else a binary search of reads and compares
// finds the segment, whose two entries feed the differences, the product and
// the bit-serial divider. One request is in work at a time; the next request
// is taken while a finished result still waits in the output register.
// Reset clears the entry count to one and empties the output register; the
// table itself holds unknown data until written. When m_axis stalls, the
// result holds and a further lookup waits at its final step.
module piecewise_linear_table_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entry_index[6:0], representation[22:7], value[38:23]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // mapped_value[15:0], mapped_representation[31:16]
  output logic [2:0]  m_axis_tuser,  // exact_hit[0], in_span[1], clamped[2]
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  plm_pkg::plm_cmd_t cmd;
  plm_pkg::plm_sts_t sts;
  logic [15:0]       mapped_value, mapped_representation;
  logic              exact_hit, in_span, clamped;

  plm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  plm_datapath u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .command_i               (s_axis_tuser),
    .entry_index_i           (s_axis_tdata[6:0]),
    .representation_i        (s_axis_tdata[22:7]),
    .value_i                 (s_axis_tdata[38:23]),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .out_ready_i             (m_axis_tready),
    .out_valid_o             (m_axis_tvalid),
    .mapped_value_o          (mapped_value),
    .mapped_representation_o (mapped_representation),
    .exact_hit_o             (exact_hit),
    .in_span_o               (in_span),
    .clamped_o               (clamped)
  );

  assign m_axis_tdata = {mapped_representation, mapped_value};
  assign m_axis_tuser = {clamped, in_span, exact_hit};

endmodule

### src/plm_checker.sv
// Port-level checks of the table mapper, bound to the top level.
`include "assert_macros.svh"

module plm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  `PLM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  `PLM_ASSERT_NOW(a_one_field_used, clk_i, rst_ni, m_axis_tvalid,
    (m_axis_tdata[15:0] == 16'h0000) || (m_axis_tdata[31:16] == 16'h0000))

  `PLM_ASSERT_NOW(a_span_not_clamped, clk_i, rst_ni, m_axis_tvalid,
    !(m_axis_tuser[1] && m_axis_tuser[2]))

  `PLM_ASSERT_NOW(a_hit_not_clamped, clk_i, rst_ni, m_axis_tvalid,
    !(m_axis_tuser[0] && m_axis_tuser[2]))

endmodule

bind piecewise_linear_table_mapper_top plm_checker u_plm_checker (.*);
